// ===== design/bmrai_pkg.sv =====
// shared types and constants for the bitmap relative-to-absolute index converter
// no dependencies; imported by bitmap_relative_to_absolute_index
`default_nettype none

package bmrai_pkg;

  // default sizes handed to the top level parameters
  localparam int BITMAP_WORDS_DEF = 1024;
  localparam int WORD_BITS_DEF    = 32;
  localparam int MAX_RELATION_DEF = 63;

  // fixed field widths
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int RID_W  = 6;
  localparam int REL_W  = 24;
  localparam int ABS_W  = 25;
  localparam int MASK_W = 64;
  localparam int WIU_W  = 11;

  // request kinds
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  // configuration register indexes
  localparam logic [0:0] CFG_REL_MASK     = 1'b0;
  localparam logic [0:0] CFG_WORDS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ST_CONVERTED = 2'd0,
    ST_ILLEGAL   = 2'd1,
    ST_NULL_KEY  = 2'd2
  } status_t;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  word_index;
    logic [DATA_W-1:0] word_data;
    logic              key_nonzero;
    logic [RID_W-1:0]  relation_id;
    logic [REL_W-1:0]  relative_index;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [RID_W-1:0] relation_out;
    logic [ABS_W-1:0] absolute_index;
  } out_t;

endpackage

`default_nettype wire

// ===== design/bitmap_relative_to_absolute_index.sv =====
// bitmap select-nth-zero converter: bitmap store, config registers, scan sequencer
// depends on bmrai_pkg
// load: written at accept, busy stays low; null or illegal key: result strobed the
// cycle after accept, busy stays low
// convert: the words are scanned one per cycle (up to words in use, capped at BITMAP_WORDS),
// then the final word is stepped bit by bit (up to WORD_BITS bit steps); a non-empty scan
// that runs past the used words ends through S_READ; busy drops in the strobe cycle, no stall
// sync active-low reset clears control and config; bitmap contents undefined until loaded
`default_nettype none

module bitmap_relative_to_absolute_index
  import bmrai_pkg::*;
#(
  parameter int BITMAP_WORDS = BITMAP_WORDS_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF,
  parameter int MAX_RELATION = MAX_RELATION_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire  in_t         in_word,
  output logic              out_valid,
  output out_t              out_word,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [0:0]        cfg_index,
  input  wire  [MASK_W-1:0] cfg_data
);

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int LW = $clog2(BITMAP_WORDS + 1);
  localparam int ZW = $clog2(WORD_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_BITS = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [MASK_W-1:0]    mask_r;
  logic [WIU_W-1:0]     words_r;

  logic [WORD_BITS-1:0] mem [BITMAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;

  logic [REL_W-1:0]     rel_r, rel_nxt;
  logic [RID_W-1:0]     rid_r, rid_nxt;
  logic [REL_W-1:0]     count_r, count_nxt;
  logic [LW-1:0]        i_r, i_nxt;
  logic [LW-1:0]        limit_r, limit_nxt;
  logic [ABS_W-1:0]     base_r, base_nxt;
  logic [ZW-1:0]        need_r, need_nxt;
  logic [WORD_BITS-1:0] bits_r, bits_nxt;

  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  logic                 accept;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rel_ok;
  logic [31:0]          lim_cap;
  logic [ZW-1:0]        zeros;
  logic [REL_W:0]       sum;
  logic                 all_ones;
  logic [LW-1:0]        i_inc;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // load path
  assign wr_en   = accept && (in_word.req_type == REQ_LOAD)
                   && (32'(in_word.word_index) < 32'(BITMAP_WORDS));
  assign wr_addr = AW'(in_word.word_index);
  assign wr_data = WORD_BITS'(in_word.word_data);

  assign rel_ok  = (32'(in_word.relation_id) <= 32'(MAX_RELATION))
                   && mask_r[in_word.relation_id];
  assign lim_cap = (32'(words_r) > 32'(BITMAP_WORDS)) ? 32'(BITMAP_WORDS) : 32'(words_r);

  // zero count of the fetched word
  always_comb begin
    zeros = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      zeros = zeros + ZW'(~rd_data_r[b]);
    end
  end

  assign all_ones = &rd_data_r;
  assign sum      = {1'b0, count_r} + (REL_W + 1)'(zeros);
  assign i_inc    = i_r + LW'(1);

  always_comb begin
    state_nxt     = state_r;
    rel_nxt       = rel_r;
    rid_nxt       = rid_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    limit_nxt     = limit_r;
    base_nxt      = base_r;
    need_nxt      = need_r;
    bits_nxt      = bits_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = i_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_word.req_type == REQ_CONVERT)) begin
          if (!in_word.key_nonzero) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_NULL_KEY, relation_out: '0, absolute_index: '0};
          end else if (!rel_ok) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_ILLEGAL, relation_out: '0, absolute_index: '0};
          end else begin
            rel_nxt   = in_word.relative_index;
            rid_nxt   = in_word.relation_id;
            count_nxt = '0;
            i_nxt     = '0;
            base_nxt  = '0;
            limit_nxt = LW'(lim_cap);
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        if (i_r < limit_r) begin
          rd_en     = 1'b1;
          state_nxt = S_EVAL;
        end else begin
          // past the used words every bit counts as zero
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_CONVERTED, relation_out: rid_r,
                            absolute_index: base_r + ABS_W'(rel_r - count_r)};
          state_nxt     = S_IDLE;
        end
      end

      S_EVAL: begin
        if (all_ones || (sum < {1'b0, rel_r})) begin
          if (!all_ones) begin
            count_nxt = sum[REL_W-1:0];
          end
          i_nxt    = i_inc;
          base_nxt = base_r + ABS_W'(WORD_BITS);
          if (i_inc < limit_r) begin
            // fetch the next word while this one is retired
            rd_en   = 1'b1;
            rd_addr = i_inc[AW-1:0];
          end else begin
            state_nxt = S_READ;
          end
        end else if (count_r == rel_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_CONVERTED, relation_out: rid_r, absolute_index: base_r};
          state_nxt     = S_IDLE;
        end else begin
          need_nxt  = ZW'(rel_r - count_r);
          bits_nxt  = rd_data_r;
          state_nxt = S_BITS;
        end
      end

      S_BITS: begin
        base_nxt = base_r + ABS_W'(1);
        bits_nxt = bits_r >> 1;
        if (!bits_r[0]) begin
          if (need_r == ZW'(1)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_CONVERTED, relation_out: rid_r,
                              absolute_index: base_r + ABS_W'(1)};
            state_nxt     = S_IDLE;
          end else begin
            need_nxt = need_r - ZW'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      words_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_REL_MASK:     mask_r  <= cfg_data;
          CFG_WORDS_IN_USE: words_r <= cfg_data[WIU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rel_r   <= rel_nxt;
    rid_r   <= rid_nxt;
    count_r <= count_nxt;
    i_r     <= i_nxt;
    limit_r <= limit_nxt;
    base_r  <= base_nxt;
    need_r  <= need_nxt;
    bits_r  <= bits_nxt;
    out_r   <= out_nxt;
  end

  // bitmap store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
